FILE: design/cipr_pkg.sv
// ----------------------------------------------------------------------------
// cipr_pkg: shared definitions for the checked in-order packet receiver
// Item and result structs, verdict codes and payload limits.
// ----------------------------------------------------------------------------
`default_nettype none

package cipr_pkg;

  // Largest number of payload bytes summed per packet
  localparam int unsigned MAX_PAYLOAD = 1024;
  localparam int unsigned CNT_W       = $clog2(MAX_PAYLOAD + 1);

  localparam int unsigned WORD_W = 16;
  localparam int unsigned LEN_W  = 11;
  localparam int unsigned BYTE_W = 8;

  // Sum of up to six 16-bit words
  localparam int unsigned ACC_W = WORD_W + 3;

  localparam logic [WORD_W-1:0] SUM_GOOD  = 16'hffff;
  localparam logic [WORD_W-1:0] SEQ_RESET = 16'h0001;

  // Verdict codes carried in the result
  typedef enum logic [1:0] {
    VERDICT_CSUM_ERR = 2'd0,
    VERDICT_IN_ORDER = 2'd1,
    VERDICT_AHEAD    = 2'd2
  } verdict_e;

  // One received item
  typedef struct packed {
    logic              first_item;
    logic              last_item;
    logic [WORD_W-1:0] pkt_seq;
    logic [WORD_W-1:0] pkt_ack;
    logic [WORD_W-1:0] pkt_syn;
    logic [LEN_W-1:0]  payload_length;
    logic [WORD_W-1:0] pkt_checksum;
    logic              byte_present;
    logic [BYTE_W-1:0] payload_byte;
  } item_t;

  // One reply
  typedef struct packed {
    logic [WORD_W-1:0] reply_seq;
    logic [WORD_W-1:0] reply_ack;
    logic              deliver;
    logic [1:0]        verdict;
  } reply_t;

endpackage

`default_nettype wire

FILE: design/cipr_in_if.sv
// ----------------------------------------------------------------------------
// cipr_in_if: packet item channel
// Valid/ready channel carrying one packet item per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface cipr_in_if;

  logic                             valid;
  logic                             ready;
  logic                             first_item;
  logic                             last_item;
  logic [cipr_pkg::WORD_W-1:0]      pkt_seq;
  logic [cipr_pkg::WORD_W-1:0]      pkt_ack;
  logic [cipr_pkg::WORD_W-1:0]      pkt_syn;
  logic [cipr_pkg::LEN_W-1:0]       payload_length;
  logic [cipr_pkg::WORD_W-1:0]      pkt_checksum;
  logic                             byte_present;
  logic [cipr_pkg::BYTE_W-1:0]      payload_byte;

  modport source (
    output valid, first_item, last_item, pkt_seq, pkt_ack, pkt_syn,
           payload_length, pkt_checksum, byte_present, payload_byte,
    input  ready
  );

  modport sink (
    input  valid, first_item, last_item, pkt_seq, pkt_ack, pkt_syn,
           payload_length, pkt_checksum, byte_present, payload_byte,
    output ready
  );

endinterface

`default_nettype wire

FILE: design/cipr_out_if.sv
// ----------------------------------------------------------------------------
// cipr_out_if: reply channel
// Valid/ready channel carrying one acknowledgment reply per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface cipr_out_if;

  logic                        valid;
  logic                        ready;
  logic [cipr_pkg::WORD_W-1:0] reply_seq;
  logic [cipr_pkg::WORD_W-1:0] reply_ack;
  logic                        deliver;
  logic [1:0]                  verdict;

  modport source (
    output valid, reply_seq, reply_ack, deliver, verdict,
    input  ready
  );

  modport sink (
    input  valid, reply_seq, reply_ack, deliver, verdict,
    output ready
  );

endinterface

`default_nettype wire

FILE: design/checked_inorder_packet_receiver.sv
// ----------------------------------------------------------------------------
// checked_inorder_packet_receiver: in-order packet receiver with checksum
// Sums header and payload in ones-complement arithmetic and acknowledges.
// ----------------------------------------------------------------------------
// The receiver takes one item per clock: the first item of a packet carries
// the header words, each item may carry one payload byte, and the last item
// closes the packet. A 16-bit ones-complement sum with end-around carry runs
// over the header words and the big-endian byte pairs, an odd final byte
// padded with zero. A last item loads the reply register as it leaves the
// item register: a checksum error repeats the previous acknowledgment, an
// in-order packet is acknowledged and marked for delivery, a packet ahead of
// the expected number re-acknowledges expected-1, and a stale packet gets no
// reply. The sustained rate is one item per cycle; it is set by the single
// sum-and-fold step between the item register and the reply register, and
// it drops only while the reply register is held by the downstream side.
`default_nettype none

module checked_inorder_packet_receiver (
  input  wire       clk_i,
  input  wire       rst_ni,
  cipr_in_if.sink   in_i,
  cipr_out_if.source out_o
);

  // Item register
  logic                  item_vld_q;
  cipr_pkg::item_t       item_q;

  // Packet state
  logic [cipr_pkg::WORD_W-1:0] expected_q, expected_d;
  logic [cipr_pkg::WORD_W-1:0] last_ack_q, last_ack_d;
  logic [cipr_pkg::WORD_W-1:0] sum_q, sum_d;
  logic [cipr_pkg::BYTE_W-1:0] held_q, held_d;
  logic                        phase_q, phase_d;
  logic [cipr_pkg::WORD_W-1:0] seq_lat_q, seq_lat_d;
  logic [cipr_pkg::CNT_W-1:0]  cnt_q, cnt_d;

  // Reply register
  logic                  out_vld_q;
  cipr_pkg::reply_t      reply_q, reply_d;

  logic                  proc_fire;
  logic                  emit;
  logic                  in_fire;

  // Working values
  logic [cipr_pkg::BYTE_W-1:0] held0, held1;
  logic                        phase0, phase1;
  logic [cipr_pkg::CNT_W-1:0]  cnt0;
  logic                        take_byte;
  logic [cipr_pkg::WORD_W-1:0] word;
  logic [cipr_pkg::ACC_W-1:0]  acc;
  logic [cipr_pkg::WORD_W:0]   fold1;
  logic [cipr_pkg::WORD_W-1:0] new_sum;

  // Advance the item stage when the reply register can take its result
  assign proc_fire = item_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !item_vld_q || proc_fire;
  assign in_fire    = in_i.valid && in_i.ready;

  // Capture item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      item_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.first_item     <= in_i.first_item;
      item_q.last_item      <= in_i.last_item;
      item_q.pkt_seq        <= in_i.pkt_seq;
      item_q.pkt_ack        <= in_i.pkt_ack;
      item_q.pkt_syn        <= in_i.pkt_syn;
      item_q.payload_length <= in_i.payload_length;
      item_q.pkt_checksum   <= in_i.pkt_checksum;
      item_q.byte_present   <= in_i.byte_present;
      item_q.payload_byte   <= in_i.payload_byte;
    end
  end

  // Byte pairing, sum and verdict
  always_comb begin
    phase0    = item_q.first_item ? 1'b0 : phase_q;
    held0     = item_q.first_item ? '0 : held_q;
    cnt0      = item_q.first_item ? '0 : cnt_q;
    seq_lat_d = item_q.first_item ? item_q.pkt_seq : seq_lat_q;

    take_byte = item_q.byte_present &&
                (cnt0 < cipr_pkg::CNT_W'(cipr_pkg::MAX_PAYLOAD));
    cnt_d  = cnt0;
    phase1 = phase0;
    held1  = held0;
    word   = '0;
    if (take_byte) begin
      cnt_d = cnt0 + 1'b1;
      if (!phase0) begin
        held1  = item_q.payload_byte;
        phase1 = 1'b1;
      end else begin
        word   = {held0, item_q.payload_byte};
        phase1 = 1'b0;
        held1  = '0;
      end
    end
    // Pad an odd final byte
    if (item_q.last_item && phase1) begin
      word = {held1, {cipr_pkg::BYTE_W{1'b0}}};
    end

    // Multi-operand sum, then fold carries end-around twice
    if (item_q.first_item) begin
      acc = cipr_pkg::ACC_W'(item_q.pkt_seq) + cipr_pkg::ACC_W'(item_q.pkt_ack)
          + cipr_pkg::ACC_W'(item_q.pkt_syn) + cipr_pkg::ACC_W'(item_q.payload_length)
          + cipr_pkg::ACC_W'(item_q.pkt_checksum) + cipr_pkg::ACC_W'(word);
    end else begin
      acc = cipr_pkg::ACC_W'(sum_q) + cipr_pkg::ACC_W'(word);
    end
    fold1   = (cipr_pkg::WORD_W+1)'(acc[cipr_pkg::WORD_W-1:0])
            + (cipr_pkg::WORD_W+1)'(acc[cipr_pkg::ACC_W-1:cipr_pkg::WORD_W]);
    new_sum = fold1[cipr_pkg::WORD_W-1:0]
            + cipr_pkg::WORD_W'(fold1[cipr_pkg::WORD_W]);

    expected_d = expected_q;
    last_ack_d = last_ack_q;
    sum_d      = new_sum;
    phase_d    = phase1;
    held_d     = held1;
    emit       = 1'b0;
    reply_d    = reply_q;

    if (item_q.last_item) begin
      // Close the packet
      sum_d   = '0;
      phase_d = 1'b0;
      held_d  = '0;
      cnt_d   = '0;
      emit    = 1'b1;
      reply_d.deliver = 1'b0;
      reply_d.verdict = cipr_pkg::VERDICT_CSUM_ERR;
      if (new_sum != cipr_pkg::SUM_GOOD) begin
        reply_d.verdict = cipr_pkg::VERDICT_CSUM_ERR;
      end else if (seq_lat_d == expected_q) begin
        last_ack_d      = seq_lat_d;
        expected_d      = expected_q + 1'b1;
        reply_d.deliver = 1'b1;
        reply_d.verdict = cipr_pkg::VERDICT_IN_ORDER;
      end else if (seq_lat_d > expected_q) begin
        last_ack_d      = expected_q - 1'b1;
        reply_d.verdict = cipr_pkg::VERDICT_AHEAD;
      end else begin
        // Stale: drop silently
        emit = 1'b0;
      end
      reply_d.reply_seq = expected_d;
      reply_d.reply_ack = last_ack_d;
    end
  end

  // Hold packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= cipr_pkg::SEQ_RESET;
      last_ack_q <= '0;
      sum_q      <= '0;
      held_q     <= '0;
      phase_q    <= 1'b0;
      seq_lat_q  <= '0;
      cnt_q      <= '0;
    end else if (proc_fire) begin
      expected_q <= expected_d;
      last_ack_q <= last_ack_d;
      sum_q      <= sum_d;
      held_q     <= held_d;
      phase_q    <= phase_d;
      seq_lat_q  <= seq_lat_d;
      cnt_q      <= cnt_d;
    end
  end

  // Reply register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc_fire) begin
      out_vld_q <= emit;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && emit) begin
      reply_q <= reply_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.reply_seq = reply_q.reply_seq;
  assign out_o.reply_ack = reply_q.reply_ack;
  assign out_o.deliver   = reply_q.deliver;
  assign out_o.verdict   = reply_q.verdict;

  // Checks
  a_deliver_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && reply_q.deliver |-> reply_q.verdict == cipr_pkg::VERDICT_IN_ORDER)
    else $error("deliver set without in-order verdict");

  a_expected_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && emit && reply_d.deliver |=> expected_q == $past(expected_q) + 1'b1)
    else $error("expected sequence did not advance on delivery");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_q && !proc_fire |-> !in_i.ready)
    else $error("input ready while item stage stalled");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && item_q.last_item |=> !phase_q && sum_q == '0 && cnt_q == '0)
    else $error("packet state not cleared after last item");

  a_reply_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready |=> out_vld_q && $stable(reply_q))
    else $error("stalled reply changed");

endmodule

`default_nettype wire

FILE: bench/cipr_reply_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cipr_reply_checker: acknowledgment predictor and comparator
// Watches the item and reply channels of the packet receiver. It keeps its
// own copy of the receiver state and the ones-complement sum, predicts the
// reply of every closed packet, and compares each reply field by field.
// ----------------------------------------------------------------------------

module cipr_reply_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  cipr_in_if          in_i,
  cipr_out_if         rep_i,
  output int unsigned mismatches_o,
  output int unsigned replies_due_o
);

  import cipr_pkg::*;

  // Receiver state as predicted
  logic [WORD_W-1:0] next_seq;
  logic [WORD_W-1:0] ack_word;
  logic [WORD_W-1:0] sum_acc;
  logic [WORD_W-1:0] seq_held;
  logic [BYTE_W-1:0] high_byte;
  logic              odd_byte;
  int unsigned       bytes_taken;

  reply_t      replies_due[$];
  int unsigned mismatches;

  assign mismatches_o = mismatches;

  // 16-bit add with end-around carry
  function automatic logic [WORD_W-1:0] ones_sum(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    s = {1'b0, s[WORD_W-1:0]} + s[WORD_W];
    return s[WORD_W-1:0];
  endfunction

  function automatic void clear_packet();
    sum_acc     = '0;
    high_byte   = '0;
    odd_byte    = 1'b0;
    bytes_taken = 0;
  endfunction

  // Fold one accepted item into the state; queue a reply when the packet closes
  task automatic absorb_item(input item_t it);
    reply_t        r;
    logic [WORD_W-1:0] s;
    bit            silent;
    silent = 1'b0;
    if (it.first_item) begin
      s = ones_sum(it.pkt_seq, it.pkt_ack);
      s = ones_sum(s, it.pkt_syn);
      s = ones_sum(s, WORD_W'(it.payload_length));
      s = ones_sum(s, it.pkt_checksum);
      clear_packet();
      sum_acc  = s;
      seq_held = it.pkt_seq;
    end
    // Pair bytes big-endian; drop anything past the payload limit
    if (it.byte_present && bytes_taken < MAX_PAYLOAD) begin
      bytes_taken++;
      if (!odd_byte) begin
        high_byte = it.payload_byte;
        odd_byte  = 1'b1;
      end else begin
        sum_acc   = ones_sum(sum_acc, {high_byte, it.payload_byte});
        odd_byte  = 1'b0;
        high_byte = '0;
      end
    end
    if (it.last_item) begin
      if (odd_byte) sum_acc = ones_sum(sum_acc, {high_byte, 8'h00});
      r.deliver = 1'b0;
      if (sum_acc != SUM_GOOD) begin
        r.verdict = VERDICT_CSUM_ERR;
      end else if (seq_held == next_seq) begin
        ack_word  = seq_held;
        next_seq  = next_seq + 1'b1;
        r.deliver = 1'b1;
        r.verdict = VERDICT_IN_ORDER;
      end else if (seq_held > next_seq) begin
        ack_word  = next_seq - 1'b1;
        r.verdict = VERDICT_AHEAD;
      end else begin
        // stale packet: no reply at all
        silent = 1'b1;
      end
      if (!silent) begin
        r.reply_seq = next_seq;
        r.reply_ack = ack_word;
        replies_due.push_back(r);
      end
      clear_packet();
    end
  endtask

  // Compare one reply with the oldest prediction
  task automatic check_reply();
    reply_t want;
    if (replies_due.size() == 0) begin
      $error("reply with none outstanding: seq %h ack %h deliver %b verdict %0d",
             rep_i.reply_seq, rep_i.reply_ack, rep_i.deliver, rep_i.verdict);
      mismatches++;
    end else begin
      want = replies_due.pop_front();
      if (rep_i.reply_seq !== want.reply_seq) begin
        $error("reply_seq: expected %h, got %h", want.reply_seq, rep_i.reply_seq);
        mismatches++;
      end
      if (rep_i.reply_ack !== want.reply_ack) begin
        $error("reply_ack: expected %h, got %h", want.reply_ack, rep_i.reply_ack);
        mismatches++;
      end
      if (rep_i.deliver !== want.deliver) begin
        $error("deliver: expected %b, got %b", want.deliver, rep_i.deliver);
        mismatches++;
      end
      if (rep_i.verdict !== want.verdict) begin
        $error("verdict: expected %0d, got %0d", want.verdict, rep_i.verdict);
        mismatches++;
      end
    end
  endtask

  // Sample both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_seq   = SEQ_RESET;
      ack_word   = '0;
      seq_held   = '0;
      mismatches = 0;
      clear_packet();
      replies_due.delete();
      replies_due_o <= 0;
    end else begin
      if (in_i.valid === 1'b1 && in_i.ready === 1'b1) begin
        absorb_item('{in_i.first_item, in_i.last_item, in_i.pkt_seq, in_i.pkt_ack,
                      in_i.pkt_syn, in_i.payload_length, in_i.pkt_checksum,
                      in_i.byte_present, in_i.payload_byte});
      end
      if (rep_i.valid === 1'b1 && rep_i.ready === 1'b1) begin
        check_reply();
      end
      replies_due_o <= replies_due.size();
    end
  end

endmodule

FILE: bench/tb_checked_inorder_packet_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_checked_inorder_packet_receiver: regression bench for the receiver
// Streams directed and random packets (good, corrupted, ahead, stale, stray
// bytes) in bursts against a stalling reply sink, and leaves the
// prediction and comparison to the reply checker.
// ----------------------------------------------------------------------------

module tb_checked_inorder_packet_receiver;

  import cipr_pkg::*;

  localparam int RANDOM_ITEMS = 420;
  localparam int LONG_HOLD    = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 16;

  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_MOSTLY,
    SINK_PERIODIC
  } sink_mode_e;

  // One item slot of a packet under construction
  typedef struct packed {
    logic              present;
    logic [BYTE_W-1:0] value;
  } slot_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  cipr_in_if  in_ch ();
  cipr_out_if out_ch ();

  int unsigned mismatches;
  int unsigned replies_due;
  int          quiet_cycles = 0;
  int          hold_requests;
  int          burst_left;
  int          items_sent;
  logic [WORD_W-1:0] link_seq;
  slot_t       pkt_slots[$];

  checked_inorder_packet_receiver dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  cipr_reply_checker u_reply_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_i          (in_ch),
    .rep_i         (out_ch),
    .mismatches_o  (mismatches),
    .replies_due_o (replies_due)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("checked_inorder_packet_receiver regression: fail");
      $finish;
    end
  end

  // Reply sink: stall in changing patterns, hold off long on request
  initial begin : reply_sink
    sink_mode_e mode;
    int         mode_left;
    int         holds_granted;
    int         tick;
    mode          = SINK_OPEN;
    mode_left     = 0;
    holds_granted = 0;
    tick          = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      tick++;
      if (holds_granted != hold_requests) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_granted++;
      end
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (mode)
        SINK_OPEN:     out_ch.ready <= 1'b1;
        SINK_COIN:     out_ch.ready <= ($urandom_range(0, 1) != 0);
        SINK_MOSTLY:   out_ch.ready <= ($urandom_range(0, 7) != 0);
        default:       out_ch.ready <= (tick % 3 != 0);
      endcase
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return WORD_W'($urandom);
  endfunction

  // Add with end-around carry, used to build valid checksums
  function automatic logic [WORD_W-1:0] wrap_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_W-1:0] + s[WORD_W];
  endfunction

  // Item with random contents in every field
  function automatic item_t noise_item();
    item_t it;
    it.first_item     = ($urandom_range(0, 1) != 0);
    it.last_item      = ($urandom_range(0, 1) != 0);
    it.pkt_seq        = rand_word();
    it.pkt_ack        = rand_word();
    it.pkt_syn        = rand_word();
    it.payload_length = LEN_W'($urandom);
    it.pkt_checksum   = rand_word();
    it.byte_present   = ($urandom_range(0, 1) != 0);
    it.payload_byte   = BYTE_W'($urandom);
    return it;
  endfunction

  task automatic drive_fields(input item_t it);
    in_ch.first_item     <= it.first_item;
    in_ch.last_item      <= it.last_item;
    in_ch.pkt_seq        <= it.pkt_seq;
    in_ch.pkt_ack        <= it.pkt_ack;
    in_ch.pkt_syn        <= it.pkt_syn;
    in_ch.payload_length <= it.payload_length;
    in_ch.pkt_checksum   <= it.pkt_checksum;
    in_ch.byte_present   <= it.byte_present;
    in_ch.payload_byte   <= it.payload_byte;
  endtask

  // Offer one item in bursts with idle gaps; return once it is taken
  task automatic send_item(input item_t it);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 64);
    end
    drive_fields(it);
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic add_slot(input bit present, input logic [BYTE_W-1:0] value);
    pkt_slots.push_back('{present, value});
  endtask

  task automatic add_random_slots(input int count, input int pct);
    repeat (count) add_slot($urandom_range(0, 99) < pct, BYTE_W'($urandom));
  endtask

  // Item outside any header: a stray byte, optionally closing the packet
  task automatic send_loose(input bit present, input logic [BYTE_W-1:0] value,
                            input bit last);
    item_t it;
    it              = noise_item();
    it.first_item   = 1'b0;
    it.last_item    = last;
    it.byte_present = present;
    it.payload_byte = value;
    send_item(it);
  endtask

  // Send the slots as one packet; a negative len_field means the true count
  task automatic send_packet(input logic [WORD_W-1:0] seq, input logic [WORD_W-1:0] ack,
                             input logic [WORD_W-1:0] syn, input bit bad_sum,
                             input int len_field);
    item_t             it;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] csum;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] high;
    bit                odd;
    int                count;
    count = 0;
    foreach (pkt_slots[i]) if (pkt_slots[i].present) count++;
    if (len_field < 0) len = LEN_W'((count > MAX_PAYLOAD) ? MAX_PAYLOAD : count);
    else len = LEN_W'(len_field);
    sum = wrap_add(wrap_add(wrap_add(seq, ack), syn), WORD_W'(len));
    // pair the bytes the receiver keeps; pad an odd one with zero
    odd   = 1'b0;
    high  = '0;
    count = 0;
    foreach (pkt_slots[i]) begin
      if (pkt_slots[i].present && count < MAX_PAYLOAD) begin
        count++;
        if (odd) sum = wrap_add(sum, {high, pkt_slots[i].value});
        else high = pkt_slots[i].value;
        odd = !odd;
      end
    end
    if (odd) sum = wrap_add(sum, {high, 8'h00});
    csum = ~sum;
    // a flip that avoids both zero encodings always breaks the sum
    if (bad_sum) csum = csum ^ WORD_W'($urandom_range(1, 16'hfffe));
    foreach (pkt_slots[i]) begin
      it            = noise_item();
      it.first_item = (i == 0);
      it.last_item  = (i == pkt_slots.size() - 1);
      if (i == 0) begin
        it.pkt_seq        = seq;
        it.pkt_ack        = ack;
        it.pkt_syn        = syn;
        it.payload_length = len;
        it.pkt_checksum   = csum;
      end
      it.byte_present = pkt_slots[i].present;
      it.payload_byte = pkt_slots[i].value;
      send_item(it);
    end
    if (!bad_sum && seq == link_seq) link_seq++;
    pkt_slots.delete();
  endtask

  initial begin : stimulus
    int  kind;
    int  len;
    int  random_start;
    bit  closed;
    hold_requests = 0;
    burst_left    = 0;
    items_sent    = 0;
    link_seq      = SEQ_RESET;
    in_ch.valid  <= 1'b0;
    drive_fields('0);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Stray bytes before any header: good sum, stale number, no reply
    send_loose(1'b1, 8'hff, 1'b0);
    send_loose(1'b1, 8'hff, 1'b1);
    // Stray byte with a bad sum draws a checksum error
    send_loose(1'b1, 8'h12, 1'b1);
    // Header and one odd byte on a single item, in order
    add_slot(1'b1, 8'ha5);
    send_packet(16'h0001, 16'h0000, 16'hffff, 1'b0, -1);
    // Byte extremes, in order
    add_slot(1'b1, 8'hff);
    add_slot(1'b1, 8'h00);
    send_packet(16'h0002, 16'hffff, 16'h0000, 1'b0, -1);
    // Corrupted checksum
    add_random_slots(3, 100);
    send_packet(16'h0003, rand_word(), rand_word(), 1'b1, -1);
    // Header only, far ahead
    add_slot(1'b0, 8'h5a);
    send_packet(16'hffff, rand_word(), rand_word(), 1'b0, -1);
    // Sequence number zero is always stale
    add_random_slots(2, 100);
    send_packet(16'h0000, rand_word(), rand_word(), 1'b0, -1);
    // Length field disagrees with the bytes, with a hole in the bytes
    add_slot(1'b1, 8'h7e);
    add_slot(1'b0, 8'h00);
    add_slot(1'b1, 8'h81);
    send_packet(16'h0003, rand_word(), rand_word(), 1'b0, MAX_PAYLOAD);
    // No payload at all
    add_slot(1'b0, 8'hc3);
    add_slot(1'b0, 8'h3c);
    send_packet(16'h0004, rand_word(), rand_word(), 1'b0, 0);
    // Below the expected number
    add_random_slots(1, 100);
    send_packet(16'h0002, rand_word(), rand_word(), 1'b0, -1);
    // Ahead by one, then in order with sparse bytes
    add_random_slots(2, 100);
    send_packet(16'h0006, rand_word(), rand_word(), 1'b0, -1);
    add_random_slots(4, 50);
    send_packet(16'h0005, rand_word(), rand_word(), 1'b0, -1);

    // Random traffic; the sink holds off long at the start to back it up
    hold_requests++;
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, MAX_PAYLOAD)) : -1;
      if (kind >= 90) begin
        // stray bytes, sometimes a pair that sums good
        closed = 1'b0;
        if ($urandom_range(0, 1)) begin
          send_loose(1'b1, 8'hff, 1'b0);
          send_loose(1'b1, 8'hff, 1'b1);
        end else begin
          repeat ($urandom_range(1, 3)) begin
            closed = ($urandom_range(0, 1) == 1);
            send_loose(($urandom_range(0, 1) != 0), BYTE_W'($urandom), closed);
          end
        end
      end else begin
        if ($urandom_range(0, 4) == 0) add_random_slots($urandom_range(7, 40), 90);
        else add_random_slots($urandom_range(1, 6),
                              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100) : 100);
        if (kind < 60) begin
          send_packet(link_seq, rand_word(), rand_word(), 1'b0, len);
        end else if (kind < 70) begin
          send_packet(link_seq, rand_word(), rand_word(), 1'b1, len);
        end else if (kind < 78) begin
          send_packet(($urandom_range(0, 7) == 0) ? 16'hffff :
                        link_seq + WORD_W'($urandom_range(1, 400)),
                      rand_word(), rand_word(), 1'b0, len);
        end else if (kind < 85) begin
          send_packet(WORD_W'($urandom_range(0, link_seq - 1)),
                      rand_word(), rand_word(), 1'b0, len);
        end else begin
          send_packet(rand_word(), rand_word(), rand_word(),
                      ($urandom_range(0, 1) != 0), len);
        end
      end
    end

    // Drain outstanding replies, then let the pipeline settle
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("checked_inorder_packet_receiver regression: pass");
    end else begin
      $display("checked_inorder_packet_receiver regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/cipr_pkg.sv
design/cipr_in_if.sv
design/cipr_out_if.sv
design/checked_inorder_packet_receiver.sv
bench/cipr_reply_checker.sv
bench/tb_checked_inorder_packet_receiver.sv
